/* rtl/rns_pkg.sv */
// Package: shared types and constants for the radius neighbor select block.
`default_nettype none
package rns_pkg;
  localparam int unsigned MaxNodes = 65536;
  localparam logic [16:0] CountLimit = (MaxNodes > 131071) ? 17'd131071 : 17'(MaxNodes);
  localparam logic [23:0] AlphaMax = 24'hFFFFFF;

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegCenterZ = 3'd2;
  localparam logic [2:0] RegAlpha   = 3'd3;
  localparam logic [2:0] RegSpacing = 3'd4;
  localparam logic [2:0] RegDims    = 3'd5;

  localparam logic [1:0] Dims2 = 2'd2;
  localparam logic [1:0] Dims3 = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input word
    logic sq_x;      // square x diff, and radius product stage
    logic sq_y;      // square y diff
    logic sq_z;      // square z diff, form radius square
    logic decide;    // compare, update count and max, fill result
    logic root_init; // start square root of max
    logic root_step; // one root iteration
    logic div_init;  // start divide
    logic div_step;  // one divide iteration
    logic finish;    // write new alpha, clear run state
  } rns_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last;
    logic root_done;
    logic div_done;
  } rns_sts_t;
endpackage
`default_nettype wire

/* rtl/rns_ctrl.sv */
// Controller: sequences one word through the datapath.
`default_nettype none
module rns_ctrl import rns_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rns_cmd_t      cmd_o,
  input  wire rns_sts_t sts_i
);
  typedef enum logic [3:0] {
    StIdle, StSqX, StSqY, StSqZ, StDecide, StRootInit, StRoot,
    StDivInit, StDiv, StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // input may be taken in idle once the result slot is free or being drained
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StSqX;
        end
      end
      StSqX: begin cmd_o.sq_x = 1'b1; state_d = StSqY; end
      StSqY: begin cmd_o.sq_y = 1'b1; state_d = StSqZ; end
      StSqZ: begin cmd_o.sq_z = 1'b1; state_d = StDecide; end
      StDecide: begin
        cmd_o.decide = 1'b1;
        if (sts_i.last) begin
          state_d = StRootInit;
        end else begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StRootInit: begin cmd_o.root_init = 1'b1; state_d = StRoot; end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) state_d = StDivInit;
      end
      StDivInit: begin cmd_o.div_init = 1'b1; state_d = StDiv; end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/rns_dp.sv */
// Datapath: config registers, distance, radius, count, max, root and divide.
`default_nettype none
module rns_dp import rns_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic signed [31:0] node_x_i,
  input  wire logic signed [31:0] node_y_i,
  input  wire logic signed [31:0] node_z_i,
  input  wire logic [15:0]        node_id_i,
  input  wire logic               last_node_i,
  input  wire rns_cmd_t           cmd_i,
  output rns_sts_t                sts_o,
  output logic [15:0]             picked_id_o,
  output logic                    selected_o,
  output logic                    done_res_o,
  output logic [16:0]             support_count_o,
  output logic [23:0]             new_alpha_o
);
  // configuration
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [23:0] alpha_q;
  logic [31:0] spacing_q;
  logic [1:0]  dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      alpha_q <= '0; spacing_q <= 32'd65536; dims_q <= Dims2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCenterX: cx_q      <= cfg_data_i;
        RegCenterY: cy_q      <= cfg_data_i;
        RegCenterZ: cz_q      <= cfg_data_i;
        RegAlpha:   alpha_q   <= cfg_data_i[23:0];
        RegSpacing: spacing_q <= cfg_data_i;
        RegDims:    dims_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // captured word and differences
  logic [31:0] ax_q, ay_q, az_q;
  logic [15:0] id_q;
  logic        last_q;
  logic [32:0] dx, dy, dz;
  assign dx = {node_x_i[31], node_x_i} - {cx_q[31], cx_q};
  assign dy = {node_y_i[31], node_y_i} - {cy_q[31], cy_q};
  assign dz = {node_z_i[31], node_z_i} - {cz_q[31], cz_q};

  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  // one 32x32 square shared by the x, y and z passes
  logic [31:0] sq_op;
  logic [63:0] sq_res;
  logic [64:0] dist_q;   // bit 64 = saturated
  logic [55:0] r_q;      // alpha*spacing
  always_comb begin
    case (1'b1)
      cmd_i.sq_y: sq_op = ay_q;
      cmd_i.sq_z: sq_op = az_q;
      default:    sq_op = ax_q;
    endcase
  end
  assign sq_res = sq_op * sq_op;

  // radius square from 32-bit partial products over the same three passes:
  // lo*lo, then 2*hi*lo, then hi*hi
  logic [31:0]  rm_a, rm_b;
  logic [63:0]  rm_res;
  logic [111:0] racc_q;
  logic [63:0]  rsq;
  always_comb begin
    case (1'b1)
      cmd_i.sq_y: begin
        rm_a = {8'd0, r_q[55:32]};
        rm_b = r_q[31:0];
      end
      cmd_i.sq_z: begin
        rm_a = {8'd0, r_q[55:32]};
        rm_b = {8'd0, r_q[55:32]};
      end
      default: begin
        rm_a = r_q[31:0];
        rm_b = r_q[31:0];
      end
    endcase
  end
  assign rm_res = rm_a * rm_b;
  assign rsq    = (racc_q[111:96] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : racc_q[95:32];

  logic [64:0] sum;
  assign sum = {1'b0, dist_q[63:0]} + {1'b0, sq_res};

  // run state
  logic [63:0] max_q;
  logic [16:0] cnt_q;
  logic        sel;
  logic [16:0] cnt_next;
  logic [63:0] dfin;
  assign dfin = dist_q[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dist_q[63:0];
  assign sel  = ((dims_q == Dims2) || (dims_q == Dims3)) && (dfin <= rsq);
  assign cnt_next = (sel && cnt_q < CountLimit) ? cnt_q + 17'd1 : cnt_q;

  // square root (bit pair per cycle) and restoring divide
  logic [63:0] rv_q, rres_q, rbit_q;
  logic [65:0] rtry;
  assign rtry = {2'b0, rres_q} + {2'b0, rbit_q};
  logic [47:0] quo_q;
  logic [32:0] rem_q;
  logic [5:0]  dcnt_q;
  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q[31:0], quo_q[47]};
  assign rem_sub = rem_sh - {1'b0, spacing_q};

  assign sts_o.last      = last_q;
  assign sts_o.root_done = (rbit_q[63:2] == '0);
  assign sts_o.div_done  = (dcnt_q == 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.decide && sel) begin
        cnt_q <= cnt_next;
        if (dfin > max_q) max_q <= dfin;
      end
      if (cmd_i.finish) begin
        max_q <= '0;
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= mag33(dx); ay_q <= mag33(dy); az_q <= mag33(dz);
      id_q <= node_id_i; last_q <= last_node_i;
      r_q  <= 56'(alpha_q) * 56'(spacing_q);
    end
    if (cmd_i.sq_x) begin
      dist_q <= {1'b0, sq_res};
      racc_q <= {48'd0, rm_res};
    end
    if (cmd_i.sq_y) begin
      dist_q <= sum[64] ? {1'b1, 64'd0} : sum;
      racc_q <= racc_q + {15'd0, rm_res, 33'd0};
    end
    if (cmd_i.sq_z) begin
      if (dims_q == Dims3 && !dist_q[64]) dist_q <= sum[64] ? {1'b1, 64'd0} : sum;
      racc_q <= racc_q + {rm_res[47:0], 64'd0};
    end
    if (cmd_i.decide) begin
      picked_id_o     <= id_q;
      selected_o      <= sel;
      done_res_o      <= last_q;
      support_count_o <= cnt_next;
      new_alpha_o     <= '0;
    end
    if (cmd_i.root_init) begin
      rv_q   <= (sel && dfin > max_q) ? dfin : max_q;
      rres_q <= '0;
      rbit_q <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.root_step) begin
      if ({2'b0, rv_q} >= rtry) begin
        rv_q   <= rv_q - rtry[63:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
    if (cmd_i.div_init) begin
      quo_q  <= {rres_q[31:0], 16'd0};
      rem_q  <= '0;
      dcnt_q <= 6'd48;
    end
    if (cmd_i.div_step) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[46:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
    end
    if (cmd_i.finish) begin
      if (spacing_q == '0) new_alpha_o <= (rres_q != '0) ? AlphaMax : 24'd0;
      else if (quo_q[47:24] != '0) new_alpha_o <= AlphaMax;
      else new_alpha_o <= quo_q[23:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/radius_neighbor_select_top.sv */
// Top level: radius neighbor select, controller plus datapath.
//
// channel | direction | signals
// in      | in        | in_valid_i / in_ready_o, node_x/y/z_i, node_id_i, last_node_i
// out     | out       | out_valid_o / out_ready_i, picked_id_o .. new_alpha_o
// cfg     | in        | cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
//
// A word goes through capture, three passes through one shared 32x32 squarer
// and the radius partial products, then compare. A last word adds root setup,
// 32 root steps, divide setup, 48 divide steps and finish. Reset clears config
// to defaults and the run state. The result waits in its output register;
// the next word is taken as it drains.
`default_nettype none
module radius_neighbor_select_top import rns_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [31:0] node_x_i,
  input  wire logic signed [31:0] node_y_i,
  input  wire logic signed [31:0] node_z_i,
  input  wire logic [15:0] node_id_i,
  input  wire logic        last_node_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      picked_id_o,
  output logic             selected_o,
  output logic             done_res_o,
  output logic [16:0]      support_count_o,
  output logic [23:0]      new_alpha_o
);
  rns_cmd_t cmd;
  rns_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rns_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  rns_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .node_x_i, .node_y_i, .node_z_i, .node_id_i, .last_node_i,
    .cmd_i(cmd), .sts_o(sts),
    .picked_id_o, .selected_o, .done_res_o, .support_count_o, .new_alpha_o
  );
endmodule
`default_nettype wire
